@@ src/tfpc_pkg.sv @@
// shared types, constants and status codes of the tdm frame pattern checker
package tfpc_pkg;

  // default frame length in slots
  localparam int FRAME_BYTES_DEF = 64;

  // configuration port geometry
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_PATTERN_STEP = 1'b0;

  localparam logic [7:0]  STEP_RESET = 8'd13;
  localparam logic [15:0] TOTAL_MAX  = 16'hFFFF;

  // per-byte check status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SLOT0_BAD  = 3'd1;
  localparam logic [2:0] ST_HIGH_RESYN = 3'd2;
  localparam logic [2:0] ST_LOW_RESYN  = 3'd3;
  localparam logic [2:0] ST_PAYLOAD    = 3'd4;

  typedef struct packed {
    logic [2:0]  check_status;
    logic [7:0]  expected_byte;
    logic [5:0]  slot_index;
    logic [15:0] frame_number;
    logic [15:0] skip_count;
    logic [15:0] error_count;
  } tfpc_result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == TOTAL_MAX) ? TOTAL_MAX : v + 16'd1;
  endfunction

endpackage

@@ src/tfpc_if.sv @@
// request channel interfaces: received bytes in, check results out
interface tfpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tfpc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  check_status;
  logic [7:0]  expected_byte;
  logic [5:0]  slot_index;
  logic [15:0] frame_number;
  logic [15:0] skip_count;
  logic [15:0] error_count;

  modport source (output valid, output check_status, output expected_byte,
                  output slot_index, output frame_number, output skip_count,
                  output error_count, input ready);
  modport sink (input valid, input check_status, input expected_byte,
                input slot_index, input frame_number, input skip_count,
                input error_count, output ready);
endinterface

@@ src/tdm_frame_pattern_checker.sv @@
// top level of the tdm frame pattern checker
//
//   channel  | direction | payload                                          | handshake
//   ---------+-----------+--------------------------------------------------+-------------
//   in_if    | in        | rx_byte                                          | valid/ready
//   out_if   | out       | check_status expected_byte slot_index            | valid/ready
//            |           | frame_number skip_count error_count              |
//   apb      | in        | pattern_step at byte address 0                   | psel/penable
//
// one byte per cycle sustained while out_if is ready; a request is held in the input register,
// is checked against the frame state and lands in the result register, from which
// it leaves when out_if.ready is high
// synchronous active-low reset clears slot position, frame counter, both totals
// and sets pattern_step to 13; no clearing pass is needed
// a stall on out_if holds the result register, and the input register still
// takes one more request before in_if.ready drops
module tdm_frame_pattern_checker import tfpc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  tfpc_in_if.sink           in_if,
  tfpc_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // configuration register
  logic [7:0] step_r;
  logic       step_sel;

  assign step_sel = (paddr[CFG_AW-1:2] == REG_PATTERN_STEP);
  assign pready   = 1'b1;
  assign prdata   = step_sel ? CFG_DW'(step_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (psel && penable && pwrite && step_sel) begin
      step_r <= pwdata[7:0];
    end
  end

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       advance;

  // result moves on when the output slot is empty or being drained
  assign advance     = in_vld_r && (!out_if.valid || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.rx_byte;
    end
  end

  // frame state and check logic
  tfpc_result_t res;

  tfpc_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .rx_byte      (in_byte_r),
    .pattern_step (step_r),
    .result       (res)
  );

  // result register
  logic         out_vld_r;
  tfpc_result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_if.valid         = out_vld_r;
  assign out_if.check_status  = out_r.check_status;
  assign out_if.expected_byte = out_r.expected_byte;
  assign out_if.slot_index    = out_r.slot_index;
  assign out_if.frame_number  = out_r.frame_number;
  assign out_if.skip_count    = out_r.skip_count;
  assign out_if.error_count   = out_r.error_count;

endmodule

@@ src/tfpc_core.sv @@
// frame state and per-byte check logic of the tdm frame pattern checker
module tfpc_core import tfpc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   pattern_step,
  output tfpc_result_t result
);

  localparam int SLOT_W = $clog2(FRAME_BYTES);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_BYTES - 1);

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [15:0]       ctr_r, ctr_nxt;
  logic [15:0]       skip_r, skip_nxt;
  logic [15:0]       err_r, err_nxt;
  logic [7:0]        slot_b;
  logic [7:0]        prod;
  logic [7:0]        expect_b;
  logic [2:0]        status;

  assign slot_b = 8'(slot_r);
  assign prod   = slot_b * pattern_step;

  always_comb begin
    ctr_nxt  = ctr_r;
    skip_nxt = skip_r;
    err_nxt  = err_r;
    status   = ST_OK;
    case (slot_b)
      8'd0: begin
        expect_b = 8'd0;
        if (rx_byte != 8'd0) begin
          status  = ST_SLOT0_BAD;
          err_nxt = sat_inc(err_r);
        end else begin
          ctr_nxt = ctr_r + 16'd1;
        end
      end
      8'd1: begin
        expect_b = ctr_r[15:8];
        if (rx_byte != expect_b) begin
          status   = ST_HIGH_RESYN;
          ctr_nxt  = {rx_byte, ctr_r[7:0]};
          skip_nxt = sat_inc(skip_r);
        end
      end
      8'd2: begin
        expect_b = ctr_r[7:0];
        if (rx_byte != expect_b) begin
          status   = ST_LOW_RESYN;
          ctr_nxt  = {ctr_r[15:8], rx_byte};
          skip_nxt = sat_inc(skip_r);
        end
      end
      default: begin
        expect_b = prod + ctr_r[7:0];
        if (rx_byte != expect_b) begin
          status  = ST_PAYLOAD;
          err_nxt = sat_inc(err_r);
        end
      end
    endcase
    slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      ctr_r  <= '0;
      skip_r <= '0;
      err_r  <= '0;
    end else if (advance) begin
      slot_r <= slot_nxt;
      ctr_r  <= ctr_nxt;
      skip_r <= skip_nxt;
      err_r  <= err_nxt;
    end
  end

  assign result.check_status  = status;
  assign result.expected_byte = expect_b;
  assign result.slot_index    = slot_b[5:0];
  assign result.frame_number  = ctr_nxt;
  assign result.skip_count    = skip_nxt;
  assign result.error_count   = err_nxt;

endmodule
